// File: rtl/time_range_segment_search_top_defines.svh
// ----------------------------------------------------------------------------
// Time range segment search: assertion macros
// Shared concurrent checks, clocked on clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef TIME_RANGE_SEGMENT_SEARCH_TOP_DEFINES_SVH
`define TIME_RANGE_SEGMENT_SEARCH_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TRSS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TRSS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/trss_pkg.sv
// ----------------------------------------------------------------------------
// Time range segment search package
// Request codes, segment table entry and search result types, frame helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package trss_pkg;

   // Request function codes; the fourth code is ignored.
   localparam logic [1:0] FUNC_APPEND = 2'd0;
   localparam logic [1:0] FUNC_QUERY  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;

   localparam int SEG_W = 10;

   typedef struct packed {
      logic [31:0] create_time;
      logic [31:0] mod_time;
      logic [31:0] first_frame;
      logic [31:0] last_frame;
   } entry_type;

   typedef struct packed {
      logic             found;
      logic [SEG_W-1:0] first_segment;
      logic [SEG_W-1:0] last_segment;
      logic [31:0]      first_frame;
      logic [31:0]      last_frame;
   } result_type;

   // Frame reached at time t inside a segment, saturating.
   function automatic logic [31:0] frame_at(entry_type e, logic [31:0] t);
      logic [32:0] sum;
      sum = {1'b0, e.first_frame} + {1'b0, t - e.create_time};
      if (e.create_time > t) begin
         frame_at = e.first_frame;
      end else if (e.mod_time < t) begin
         frame_at = e.last_frame;
      end else if (sum[32]) begin
         frame_at = '1;
      end else begin
         frame_at = sum[31:0];
      end
   endfunction

endpackage

`default_nettype wire

// File: rtl/trss_table.sv
// ----------------------------------------------------------------------------
// Segment table
// Single-port synchronous RAM, one entry per segment, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trss_table import trss_pkg::*; #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           wr_en,
   input  wire logic [$clog2(TABLE_DEPTH)-1:0] addr,
   input  wire entry_type                      wr_data,
   output      entry_type                      rd_data
);

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/trss_search.sv
// ----------------------------------------------------------------------------
// Segment search sequencer
// Boundary reads, up to two binary interval searches, boundary fix-up, frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trss_search import trss_pkg::*; #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             q_start,
   input  wire logic [31:0]                      q_start_time,
   input  wire logic [31:0]                      q_end_time,
   input  wire logic [$clog2(TABLE_DEPTH+1)-1:0] seg_count,
   output      logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr,
   input  wire entry_type                        rd_data,
   output      logic                             idle,
   output      logic                             res_valid,
   input  wire logic                             res_take,
   output      result_type                       res
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_CAP_LAST  = 4'd1;
   localparam logic [3:0] S_CAP_FIRST = 4'd2;
   localparam logic [3:0] S_SRCH      = 4'd3;
   localparam logic [3:0] S_CAP_SI    = 4'd4;
   localparam logic [3:0] S_CAP_EI    = 4'd5;
   localparam logic [3:0] S_CAP_FS    = 4'd6;
   localparam logic [3:0] S_CAP_FE    = 4'd7;
   localparam logic [3:0] S_DONE      = 4'd8;

   logic [3:0]       state_ff, state_in;
   logic [31:0]      st_ff, st_in, et_ff, et_in, mod_last_ff, mod_last_in;
   logic [CNT_W-1:0] n_ff, n_in, si_ff, si_in, ei_ff, ei_in;
   logic             si_v_ff, si_v_in, ei_v_ff, ei_v_in;
   logic             phase_ff, phase_in, need_end_ff, need_end_in;
   logic [IDX_W-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic             found_ff, found_in;
   logic [31:0]      ffr_ff, ffr_in, lfr_ff, lfr_in;

   logic [CNT_W-1:0] cnt_last, req_cnt_last, si_sel, ei_sel, ei_adj;
   logic [IDX_W-1:0] last_idx, init_mid, req_mid_unused, nmid_lo, nmid_hi, srch_idx;
   logic [31:0]      t_cur;
   logic             hit, s_none, s_zero, e_none, e_last, single_miss, ei_dec, go_post;
   logic [CNT_W+SEG_W-1:0] si_ext, ei_ext;

   assign cnt_last       = n_ff - CNT_W'(1);
   assign req_cnt_last   = seg_count - CNT_W'(1);
   assign last_idx       = cnt_last[IDX_W-1:0];
   assign init_mid       = last_idx >> 1;
   assign req_mid_unused = req_cnt_last[IDX_W-1:0];
   assign nmid_lo        = lo_ff + ((mid_ff - lo_ff) >> 1);
   assign nmid_hi        = mid_ff + ((hi_ff - mid_ff) >> 1);
   assign t_cur          = phase_ff ? et_ff : st_ff;
   assign hit            = (rd_data.mod_time >= t_cur) && (rd_data.create_time <= t_cur);
   assign srch_idx       = hit ? mid_ff : hi_ff;

   // Outer bounds, valid in S_CAP_FIRST (entry 0 on the read port)
   assign s_none = mod_last_ff < st_ff;
   assign s_zero = rd_data.create_time >= st_ff;
   assign e_none = (rd_data.create_time > et_ff) || (mod_last_ff < st_ff);
   assign e_last = mod_last_ff <= et_ff;

   // Boundary fix-up
   assign si_sel      = si_v_ff ? si_ff : '0;
   assign ei_sel      = ei_v_ff ? ei_ff : cnt_last;
   assign single_miss = si_v_ff && ei_v_ff && (si_ff == ei_ff) &&
                        ((rd_data.create_time > et_ff) || (rd_data.mod_time < st_ff));
   assign ei_dec      = rd_data.create_time > et_ff;
   assign ei_adj      = ei_ff - CNT_W'(ei_dec);

   always_comb begin
      state_in    = state_ff;
      st_in       = st_ff;
      et_in       = et_ff;
      n_in        = n_ff;
      mod_last_in = mod_last_ff;
      si_in       = si_ff;
      ei_in       = ei_ff;
      si_v_in     = si_v_ff;
      ei_v_in     = ei_v_ff;
      phase_in    = phase_ff;
      need_end_in = need_end_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      found_in    = found_ff;
      ffr_in      = ffr_ff;
      lfr_in      = lfr_ff;
      rd_addr     = mid_ff;
      go_post     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            rd_addr = req_mid_unused;
            if (q_start) begin
               st_in    = q_start_time;
               et_in    = q_end_time;
               n_in     = seg_count;
               found_in = 1'b0;
               if (seg_count == '0 || q_start_time > q_end_time) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_CAP_LAST;
               end
            end
         end
         S_CAP_LAST: begin
            mod_last_in = rd_data.mod_time;
            rd_addr     = '0;
            state_in    = S_CAP_FIRST;
         end
         S_CAP_FIRST: begin
            si_v_in     = !s_none;
            si_in       = '0;
            ei_v_in     = !e_none;
            ei_in       = cnt_last;
            need_end_in = !e_none && !e_last;
            lo_in       = '0;
            hi_in       = last_idx;
            mid_in      = init_mid;
            rd_addr     = init_mid;
            if (!s_none && !s_zero) begin
               phase_in = 1'b0;
               state_in = S_SRCH;
            end else if (!e_none && !e_last) begin
               phase_in = 1'b1;
               state_in = S_SRCH;
            end else begin
               go_post = 1'b1;
            end
         end
         S_SRCH: begin
            if (hit || mid_ff == lo_ff) begin
               if (!phase_ff) begin
                  si_in = CNT_W'(srch_idx);
                  if (need_end_ff) begin
                     phase_in = 1'b1;
                     lo_in    = '0;
                     hi_in    = last_idx;
                     mid_in   = init_mid;
                     rd_addr  = init_mid;
                  end else begin
                     go_post = 1'b1;
                  end
               end else begin
                  ei_in   = CNT_W'(srch_idx);
                  go_post = 1'b1;
               end
            end else if (rd_data.mod_time >= t_cur) begin
               hi_in   = mid_ff;
               mid_in  = nmid_lo;
               rd_addr = nmid_lo;
            end else begin
               lo_in   = mid_ff;
               mid_in  = nmid_hi;
               rd_addr = nmid_hi;
            end
         end
         S_CAP_SI: begin
            if (single_miss) begin
               found_in = 1'b0;
               state_in = S_DONE;
            end else begin
               si_in    = si_sel + CNT_W'(rd_data.mod_time < st_ff);
               ei_in    = ei_sel;
               rd_addr  = ei_sel[IDX_W-1:0];
               state_in = S_CAP_EI;
            end
         end
         S_CAP_EI: begin
            if ((ei_dec && ei_ff == '0) || si_ff > ei_adj || si_ff >= n_ff) begin
               found_in = 1'b0;
               state_in = S_DONE;
            end else begin
               ei_in    = ei_adj;
               rd_addr  = si_ff[IDX_W-1:0];
               state_in = S_CAP_FS;
            end
         end
         S_CAP_FS: begin
            ffr_in   = frame_at(rd_data, st_ff);
            rd_addr  = ei_ff[IDX_W-1:0];
            state_in = S_CAP_FE;
         end
         S_CAP_FE: begin
            lfr_in   = frame_at(rd_data, et_ff);
            found_in = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Both ends known: read the start boundary entry, or give up
      if (go_post) begin
         if (!si_v_in && !ei_v_in) begin
            found_in = 1'b0;
            state_in = S_DONE;
         end else begin
            rd_addr  = si_v_in ? si_in[IDX_W-1:0] : '0;
            state_in = S_CAP_SI;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      st_ff       <= st_in;
      et_ff       <= et_in;
      n_ff        <= n_in;
      mod_last_ff <= mod_last_in;
      si_ff       <= si_in;
      ei_ff       <= ei_in;
      si_v_ff     <= si_v_in;
      ei_v_ff     <= ei_v_in;
      phase_ff    <= phase_in;
      need_end_ff <= need_end_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      found_ff    <= found_in;
      ffr_ff      <= ffr_in;
      lfr_ff      <= lfr_in;
   end

   assign si_ext = {{SEG_W{1'b0}}, si_ff};
   assign ei_ext = {{SEG_W{1'b0}}, ei_ff};

   assign idle      = state_ff == S_IDLE;
   assign res_valid = state_ff == S_DONE;

   assign res.found         = found_ff;
   assign res.first_segment = found_ff ? si_ext[SEG_W-1:0] : '0;
   assign res.last_segment  = found_ff ? ei_ext[SEG_W-1:0] : '0;
   assign res.first_frame   = found_ff ? ffr_ff : '0;
   assign res.last_frame    = found_ff ? lfr_ff : '0;

endmodule

`default_nettype wire

// File: rtl/time_range_segment_search_top.sv
// ----------------------------------------------------------------------------
// Time range segment search, top level
// Timing: append and clear are registered at acceptance; a query result is
//   valid after the boundary reads, up to two binary searches, the fix-up
//   and the frame reads, set by one read of the single-port segment RAM a cycle.
// Throughput: one query at a time; appends and clears one per cycle when idle.
// Reset: segment count and handshake state clear; RAM contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "time_range_segment_search_top_defines.svh"

module time_range_segment_search_top import trss_pkg::*; #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic [31:0] req_seg_create_time,
   input  wire logic [31:0] req_seg_mod_time,
   input  wire logic [31:0] req_seg_start_frame,
   input  wire logic [31:0] req_seg_end_frame,
   input  wire logic [31:0] req_query_start_time,
   input  wire logic [31:0] req_query_end_time,
   // result channel
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic        rsp_found,
   output      logic [9:0]  rsp_first_segment,
   output      logic [9:0]  rsp_last_segment,
   output      logic [31:0] rsp_first_frame,
   output      logic [31:0] rsp_last_frame
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

   logic             req_fire, is_append, is_query, is_clear;
   logic             wr_en, full_append;
   logic [IDX_W-1:0] tbl_addr, srch_addr;
   entry_type        wr_data, rd_data;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             srch_idle, res_valid, res_take, out_free;
   result_type       res;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_res_ff;

   // A request is taken only while the sequencer is idle, so a table write
   // and a search read never share a cycle on the single RAM port.
   assign req_ready = srch_idle;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      is_append = 1'b0;
      is_query  = 1'b0;
      is_clear  = 1'b0;
      unique case (req_func)
         FUNC_APPEND: is_append = 1'b1;
         FUNC_QUERY:  is_query  = 1'b1;
         FUNC_CLEAR:  is_clear  = 1'b1;
         default: begin
         end
      endcase
   end

   // Appends to a full table are dropped.
   assign wr_en       = req_fire && is_append && (count_ff != CNT_FULL);
   assign full_append = req_fire && is_append && (count_ff == CNT_FULL);
   assign tbl_addr    = wr_en ? count_ff[IDX_W-1:0] : srch_addr;

   assign wr_data.create_time = req_seg_create_time;
   assign wr_data.mod_time    = req_seg_mod_time;
   assign wr_data.first_frame = req_seg_start_frame;
   assign wr_data.last_frame  = req_seg_end_frame;

   always_comb begin
      count_in = count_ff;
      if (req_fire && is_clear) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   trss_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .addr    (tbl_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   trss_search #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_search (
      .clock        (clock),
      .reset        (reset),
      .q_start      (req_fire && is_query),
      .q_start_time (req_query_start_time),
      .q_end_time   (req_query_end_time),
      .seg_count    (count_ff),
      .rd_addr      (srch_addr),
      .rd_data      (rd_data),
      .idle         (srch_idle),
      .res_valid    (res_valid),
      .res_take     (res_take),
      .res          (res)
   );

   // Output register: the sequencer parks its result until this stage frees.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign res_take = res_valid && out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_take) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_res_ff.found;
   assign rsp_first_segment = rsp_res_ff.first_segment;
   assign rsp_last_segment  = rsp_res_ff.last_segment;
   assign rsp_first_frame   = rsp_res_ff.first_frame;
   assign rsp_last_frame    = rsp_res_ff.last_frame;

   `TRSS_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CNT_FULL, "segment count past depth")
   `TRSS_ASSERT_SAME(a_write_idle, wr_en, srch_idle, "table write during search")
   `TRSS_ASSERT_NEXT(a_query_busy, req_fire && is_query, !srch_idle, "query not started")
   `TRSS_ASSERT_NEXT(a_clear_empty, req_fire && is_clear, count_ff == '0, "clear missed")
   `TRSS_ASSERT_NEXT(a_full_drop, full_append, count_ff == CNT_FULL, "full append changed count")

endmodule

`default_nettype wire
